// ===== rtl/core/kr_pkg.sv =====
`timescale 1ns / 1ps

package kr_pkg;

    localparam int ENTRIES_DEF = 64;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_SELECT = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXISTS    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // request token walking the cell chain
    typedef struct packed {
        logic               valid;
        logic [2:0]         operation;
        logic signed [31:0] key;
        logic [63:0]        name_word;
        logic               hit;
        logic               free_found;
    } tok_t;

    // insert write-back broadcast to every cell
    typedef struct packed {
        logic               we;
        logic signed [31:0] key;
        logic [63:0]        name_word;
    } wr_t;

endpackage

// ===== rtl/core/kr_if.sv =====
`timescale 1ns / 1ps

interface kr_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [31:0] key;
    logic [63:0]        name_word;

    modport source (output valid, output operation, output key, output name_word,
                    input ready);
    modport sink   (input valid, input operation, input key, input name_word,
                    output ready);
endinterface

interface kr_rsp_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [2:0]         status;
    logic signed [31:0] row_key;
    logic [63:0]        row_name;

    modport source (output valid, output ok, output status, output row_key,
                    output row_name, input ready);
    modport sink   (input valid, input ok, input status, input row_key,
                    input row_name, output ready);
endinterface

// ===== rtl/core/keyed_record_table.sv =====
`timescale 1ns / 1ps

// Keyed record table: up to ENTRIES records of a signed 32-bit key and a
// 64-bit name word, keys unique.
// Channels: req carries one request word (operation, key, name_word);
// rsp returns exactly one response word (ok, status, row_key, row_name)
// per request, in order. Both use valid/ready; a word moves when both are
// high at a rising edge of clk.
// Each slot lives in one cell of a chain. A request walks the chain one cell
// per cycle: each cell compares its key, deletes or updates in place on a
// match, hands its name forward on select, and marks the first free slot.
// At the end of the chain an insert is written back to that free slot.
// A request passes through the input register, each cell register in turn,
// and the response register. One request is in flight at a time, so a new
// request is taken only after the previous response is registered.
// Reset (rst_n low) empties the table at once and drops any word in flight.
// If the receiver stalls, the response holds in the output register; the
// next request may be taken meanwhile and halts at the chain end until the
// output register frees.

module keyed_record_table #(
    parameter int ENTRIES = kr_pkg::ENTRIES_DEF,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    kr_req_if.sink        req,
    kr_rsp_if.source      rsp
);

    kr_pkg::tok_t     tok  [ENTRIES+1];
    logic [IDX_W-1:0] fidx [ENTRIES+1];

    kr_pkg::tok_t       tok0_reg;
    logic               busy_reg;
    logic               rsp_valid_reg;
    logic               ok_reg;
    logic [2:0]         status_reg;
    logic signed [31:0] row_key_reg;
    logic [63:0]        row_name_reg;

    kr_pkg::tok_t       tend;
    kr_pkg::wr_t        wr;
    logic               accept;
    logic               adv;
    logic               fire;
    logic [2:0]         status_next;
    logic               hit_out;

    assign accept = req.valid && req.ready;
    assign tend   = tok[ENTRIES];
    assign adv    = !(tend.valid && rsp_valid_reg && !rsp.ready);
    assign fire   = tend.valid && adv;

    assign tok[0]  = tok0_reg;
    assign fidx[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            kr_cell #(
                .ENTRIES (ENTRIES),
                .INDEX   (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .tin      (tok[gi]),
                .fidx_in  (fidx[gi]),
                .tout     (tok[gi+1]),
                .fidx_out (fidx[gi+1]),
                .wr       (wr),
                .wr_idx   (fidx[ENTRIES])
            );
        end
    endgenerate

    always_comb
    begin
        wr.we        = fire && (tend.operation == kr_pkg::OP_INSERT) && !tend.hit
                       && tend.free_found;
        wr.key       = tend.key;
        wr.name_word = tend.name_word;
    end

    always_comb
    begin
        hit_out = 1'b0;
        case (tend.operation)
            kr_pkg::OP_INSERT:
            begin
                if (tend.hit)
                    status_next = kr_pkg::ST_EXISTS;
                else if (tend.free_found)
                    status_next = kr_pkg::ST_OK;
                else
                    status_next = kr_pkg::ST_FULL;
            end
            kr_pkg::OP_DELETE:
                status_next = tend.hit ? kr_pkg::ST_OK : kr_pkg::ST_NOT_FOUND;
            kr_pkg::OP_SELECT, kr_pkg::OP_UPDATE:
            begin
                status_next = tend.hit ? kr_pkg::ST_OK : kr_pkg::ST_NOT_FOUND;
                hit_out     = tend.hit;
            end
            default:
                status_next = kr_pkg::ST_INVALID;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            tok0_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                busy_reg <= 1'b1;
            else if (fire)
                busy_reg <= 1'b0;

            if (accept)
            begin
                tok0_reg.valid      <= 1'b1;
                tok0_reg.operation  <= req.operation;
                tok0_reg.key        <= req.key;
                tok0_reg.name_word  <= req.name_word;
                tok0_reg.hit        <= 1'b0;
                tok0_reg.free_found <= 1'b0;
            end
            else if (adv)
                tok0_reg.valid <= 1'b0;

            if (fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ok_reg       <= (status_next == kr_pkg::ST_OK);
            status_reg   <= status_next;
            row_key_reg  <= hit_out ? tend.key : 32'sd0;
            row_name_reg <= hit_out ? tend.name_word : 64'd0;
        end
    end

    assign req.ready    = !busy_reg;
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.ok       = ok_reg;
    assign rsp.status   = status_reg;
    assign rsp.row_key  = row_key_reg;
    assign rsp.row_name = row_name_reg;

endmodule

// ===== rtl/core/kr_cell.sv =====
`timescale 1ns / 1ps

module kr_cell #(
    parameter int ENTRIES = kr_pkg::ENTRIES_DEF,
    parameter int INDEX   = 0,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  kr_pkg::tok_t      tin,
    input  logic [IDX_W-1:0]  fidx_in,
    output kr_pkg::tok_t      tout,
    output logic [IDX_W-1:0]  fidx_out,
    input  kr_pkg::wr_t       wr,
    input  logic [IDX_W-1:0]  wr_idx
);

    localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

    logic               valid_reg, valid_next;
    logic signed [31:0] key_reg, key_next;
    logic [63:0]        name_reg, name_next;
    kr_pkg::tok_t       tok_reg, tok_next;
    logic [IDX_W-1:0]   fidx_reg, fidx_next;
    logic               match;

    assign match = valid_reg && (key_reg == tin.key);

    always_comb
    begin
        tok_next   = tin;
        fidx_next  = fidx_in;
        valid_next = valid_reg;
        key_next   = key_reg;
        name_next  = name_reg;
        if (tin.valid)
        begin
            if (match)
            begin
                tok_next.hit = 1'b1;
                case (tin.operation)
                    kr_pkg::OP_SELECT: tok_next.name_word = name_reg;
                    kr_pkg::OP_DELETE: valid_next = 1'b0;
                    kr_pkg::OP_UPDATE: name_next = tin.name_word;
                    default: ;
                endcase
            end
            if (!valid_reg && !tin.free_found)
            begin
                tok_next.free_found = 1'b1;
                fidx_next           = IDX;
            end
        end
        if (wr.we && (wr_idx == IDX))
        begin
            valid_next = 1'b1;
            key_next   = wr.key;
            name_next  = wr.name_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg  <= key_next;
            name_reg <= name_next;
            fidx_reg <= fidx_next;
        end
    end

    assign tout     = tok_reg;
    assign fidx_out = fidx_reg;

endmodule

// ===== rtl/core/kr_checker.sv =====
`timescale 1ns / 1ps

module kr_checker (
    input  logic      clk,
    input  logic      rst_n,
    kr_req_if.sink    req,
    kr_rsp_if.source  rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.ok) && $stable(rsp.status)
            && $stable(rsp.row_key) && $stable(rsp.row_name))
        else $error("response word changed while stalled");

    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.ok == (rsp.status == kr_pkg::ST_OK)))
        else $error("ok does not agree with status");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ok |-> (rsp.row_key == 32'sd0) && (rsp.row_name == 64'd0))
        else $error("failed response carries a record");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.status == kr_pkg::ST_OK) || (rsp.status == kr_pkg::ST_EXISTS)
            || (rsp.status == kr_pkg::ST_NOT_FOUND) || (rsp.status == kr_pkg::ST_INVALID)
            || (rsp.status == kr_pkg::ST_FULL))
        else $error("unknown status code");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in flight");

endmodule

bind keyed_record_table kr_checker u_kr_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);

// ===== dv/tb_keyed_record_table.sv =====
`timescale 1ns / 1ps

module tb_keyed_record_table;

    localparam int SLOTS       = kr_pkg::ENTRIES_DEF;
    localparam int PHASE_LEN   = 290;
    localparam int FILL_LEN    = 140;
    localparam int BALANCE_LEN = 143;
    localparam int KEY_POOL    = 80;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = SLOTS + 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int REPORT_MAX  = 10;

    localparam logic [2:0] OP_FIRST_BAD = kr_pkg::OP_UPDATE + 3'd1;
    localparam logic [2:0] OP_LAST_BAD  = 3'd7;

    localparam logic signed [31:0] KEY_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] KEY_ZERO = 32'sh0000_0000;
    localparam logic signed [31:0] KEY_NEG1 = 32'shFFFF_FFFF;
    localparam logic [63:0] NAME_ZERO = 64'h0;
    localparam logic [63:0] NAME_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] key;
        logic [63:0]        name_word;
    } request_t;

    typedef struct packed {
        logic               ok;
        logic [2:0]         status;
        logic signed [31:0] row_key;
        logic [63:0]        row_name;
    } response_t;

    logic clk;
    logic rst_n;

    kr_req_if req_bus ();
    kr_rsp_if rsp_bus ();

    keyed_record_table #(.ENTRIES(SLOTS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    logic               rec_live [SLOTS];
    logic signed [31:0] rec_key  [SLOTS];
    logic [63:0]        rec_name [SLOTS];

    logic signed [31:0] key_pool [KEY_POOL];

    request_t  request_backlog [$];
    response_t pending_responses [$];

    int requests_taken;
    int requests_total;
    int mismatches;
    int hold_left;
    bit hold_done;
    int cycles;

    function automatic int find_key(logic signed [31:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (rec_live[i] && rec_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int first_hole();
        for (int i = 0; i < SLOTS; i++)
            if (!rec_live[i])
                return i;
        return -1;
    endfunction

    function automatic response_t apply_request(request_t r);
        response_t res;
        int hit;
        int hole;
        res = '0;
        res.status = kr_pkg::ST_OK;
        hit = find_key(r.key);
        case (r.operation)
            kr_pkg::OP_INSERT:
            begin
                if (hit >= 0)
                    res.status = kr_pkg::ST_EXISTS;
                else
                begin
                    hole = first_hole();
                    if (hole < 0)
                        res.status = kr_pkg::ST_FULL;
                    else
                    begin
                        rec_live[hole] = 1'b1;
                        rec_key[hole]  = r.key;
                        rec_name[hole] = r.name_word;
                    end
                end
            end
            kr_pkg::OP_DELETE:
            begin
                if (hit < 0)
                    res.status = kr_pkg::ST_NOT_FOUND;
                else
                    rec_live[hit] = 1'b0;
            end
            kr_pkg::OP_SELECT, kr_pkg::OP_UPDATE:
            begin
                if (hit < 0)
                    res.status = kr_pkg::ST_NOT_FOUND;
                else
                begin
                    if (r.operation == kr_pkg::OP_UPDATE)
                        rec_name[hit] = r.name_word;
                    res.row_key  = rec_key[hit];
                    res.row_name = rec_name[hit];
                end
            end
            default:
                res.status = kr_pkg::ST_INVALID;
        endcase
        res.ok = (res.status == kr_pkg::ST_OK);
        return res;
    endfunction

    function automatic request_t random_request(bit filling);
        request_t r;
        int pick;
        pick = $urandom_range(99);
        r.name_word = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            r.key = $urandom;
        else
            r.key = key_pool[$urandom_range(KEY_POOL - 1)];
        if (pick < 4)
            r.operation = 3'($urandom_range(OP_FIRST_BAD, OP_LAST_BAD));
        else if (pick < (filling ? 74 : 28))
            r.operation = kr_pkg::OP_INSERT;
        else if (pick < (filling ? 84 : 58))
            r.operation = kr_pkg::OP_DELETE;
        else if (pick < (filling ? 92 : 79))
            r.operation = kr_pkg::OP_SELECT;
        else
            r.operation = kr_pkg::OP_UPDATE;
        return r;
    endfunction

    task automatic queue_request(logic [2:0] op, logic signed [31:0] k, logic [63:0] nm);
        request_t r;
        r.operation = op;
        r.key       = k;
        r.name_word = nm;
        request_backlog = {request_backlog, r};
    endtask

    function automatic int idle_phase();
        if (requests_taken < PHASE_LEN)
            return 0;
        if (requests_taken < 2 * PHASE_LEN)
            return 1;
        return 2;
    endfunction

    function automatic bit sender_idles();
        case (idle_phase())
            0:       return $urandom_range(99) < 34;
            1:       return $urandom_range(99) < 51;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idles();
        case (idle_phase())
            0:       return $urandom_range(99) < 51;
            1:       return $urandom_range(99) < 34;
            default: return 1'b0;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // drive request words
    always @(posedge clk or negedge rst_n)
    begin
        request_t nxt;
        logic     nxt_valid;
        if (!rst_n)
        begin
            req_bus.valid     <= 1'b0;
            req_bus.operation <= kr_pkg::OP_INSERT;
            req_bus.key       <= KEY_ZERO;
            req_bus.name_word <= NAME_ZERO;
            requests_taken    <= 0;
        end
        else
        begin
            nxt_valid = req_bus.valid;
            nxt       = {req_bus.operation, req_bus.key, req_bus.name_word};
            if (req_bus.valid && req_bus.ready)
            begin
                pending_responses = {pending_responses, apply_request(nxt)};
                requests_taken <= requests_taken + 1;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && request_backlog.size() > 0 && !sender_idles())
            begin
                nxt       = request_backlog.pop_front();
                nxt_valid = 1'b1;
            end
            req_bus.valid     <= nxt_valid;
            req_bus.operation <= nxt.operation;
            req_bus.key       <= nxt.key;
            req_bus.name_word <= nxt.name_word;
        end
    end

    // hold off the response channel once, long enough to back up the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && requests_taken >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // check response words
    always @(posedge clk or negedge rst_n)
    begin
        response_t got;
        response_t want;
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got = {rsp_bus.ok, rsp_bus.status, rsp_bus.row_key, rsp_bus.row_name};
                if (pending_responses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected word: ok=%0b status=%0d key=%0d name=%h",
                                 got.ok, got.status, got.row_key, got.row_name);
                end
                else
                begin
                    want = pending_responses.pop_front();
                    if (got.ok !== want.ok || got.status !== want.status ||
                        got.row_key !== want.row_key || got.row_name !== want.row_name)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"word mismatch: exp ok=%0b status=%0d key=%0d name=%h,",
                                      " got ok=%0b status=%0d key=%0d name=%h"},
                                     want.ok, want.status, want.row_key, want.row_name,
                                     got.ok, got.status, got.row_key, got.row_name);
                    end
                end
            end
            rsp_bus.ready <= (hold_left == 0) && !receiver_idles();
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.operation = kr_pkg::OP_INSERT;
        req_bus.key       = KEY_ZERO;
        req_bus.name_word = NAME_ZERO;
        rsp_bus.ready     = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            rec_live[i] = 1'b0;

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = KEY_ZERO;
        key_pool[3] = KEY_NEG1;
        for (int i = 4; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        queue_request(kr_pkg::OP_SELECT, KEY_ZERO, NAME_ZERO);
        queue_request(kr_pkg::OP_DELETE, KEY_ZERO, NAME_ONES);
        queue_request(kr_pkg::OP_UPDATE, KEY_MAX, NAME_ONES);
        queue_request(kr_pkg::OP_INSERT, KEY_MIN, NAME_ZERO);
        queue_request(kr_pkg::OP_INSERT, KEY_MAX, NAME_ONES);
        queue_request(kr_pkg::OP_INSERT, KEY_ZERO, 64'h0123_4567_89AB_CDEF);
        queue_request(kr_pkg::OP_INSERT, KEY_MIN, NAME_ONES);
        queue_request(kr_pkg::OP_SELECT, KEY_MIN, NAME_ONES);
        queue_request(kr_pkg::OP_SELECT, KEY_MAX, NAME_ZERO);
        queue_request(kr_pkg::OP_UPDATE, KEY_MAX, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_request(kr_pkg::OP_UPDATE, KEY_MIN, 64'h5555_5555_5555_5555);
        queue_request(kr_pkg::OP_SELECT, KEY_MIN, NAME_ZERO);
        queue_request(kr_pkg::OP_DELETE, KEY_MIN, NAME_ZERO);
        queue_request(kr_pkg::OP_SELECT, KEY_MIN, NAME_ZERO);
        queue_request(kr_pkg::OP_INSERT, KEY_NEG1, NAME_ONES);
        queue_request(kr_pkg::OP_DELETE, KEY_MIN, NAME_ZERO);
        for (int c = OP_FIRST_BAD; c <= OP_LAST_BAD; c++)
            queue_request(3'(c), KEY_MAX, {$urandom, $urandom});
        queue_request(kr_pkg::OP_INSERT, KEY_MIN, NAME_ONES);
        queue_request(kr_pkg::OP_DELETE, KEY_ZERO, NAME_ZERO);
        queue_request(kr_pkg::OP_DELETE, KEY_NEG1, NAME_ZERO);
        queue_request(kr_pkg::OP_DELETE, KEY_MAX, NAME_ZERO);
        queue_request(kr_pkg::OP_DELETE, KEY_MIN, NAME_ZERO);

        for (int p = 0; p < 3; p++)
        begin
            for (int i = 0; i < FILL_LEN; i++)
                request_backlog = {request_backlog, random_request(1'b1)};
            for (int i = 0; i < BALANCE_LEN; i++)
                request_backlog = {request_backlog, random_request(1'b0)};
        end
        requests_total = request_backlog.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_taken < requests_total)
            @(posedge clk);
        while (pending_responses.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0 && pending_responses.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/kr_pkg.sv
rtl/core/kr_if.sv
rtl/core/kr_cell.sv
rtl/core/keyed_record_table.sv
rtl/core/kr_checker.sv
dv/tb_keyed_record_table.sv
